// ===== design/assert_macros.svh =====
// Assertion macros used by the validator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/utf8v_pkg.sv =====
// Package: error codes and constants for the UTF-8 name validator.
`timescale 1ns / 1ps

package utf8v_pkg;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_CONTROL = 3'd1,
		ERR_LEAD    = 3'd2,
		ERR_CONT    = 3'd3,
		ERR_TRUNC   = 3'd4,
		ERR_POINT   = 3'd5,
		ERR_LONG    = 3'd6
	} err_t;

	localparam logic [7:0]  MAX_BYTES_RST = 8'd32;
	localparam logic [8:0]  COUNT_MAX     = 9'd511;
	localparam logic [7:0]  CTRL_LIMIT    = 8'h20;
	localparam logic [7:0]  DEL_BYTE      = 8'h7F;
	localparam logic [20:0] CP_MIN_2      = 21'h00080;
	localparam logic [20:0] CP_MIN_3      = 21'h00800;
	localparam logic [20:0] CP_MIN_4      = 21'h10000;
	localparam logic [20:0] CP_MAX        = 21'h10FFFF;
	localparam logic [20:0] C1_LO         = 21'h00080;
	localparam logic [20:0] C1_HI         = 21'h0009F;
	localparam logic [20:0] SURR_LO       = 21'h0D800;
	localparam logic [20:0] SURR_HI       = 21'h0DFFF;

endpackage

// ===== design/utf8v_if.sv =====
// Interfaces: byte stream channel and result channel.
`timescale 1ns / 1ps

interface utf8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_res_if;
	logic       valid;
	logic       ready;
	logic       text_ok;
	logic [2:0] fault_code;
	logic [8:0] byte_count;

	modport source (output valid, output text_ok, output fault_code, output byte_count,
		input ready);
	modport sink (input valid, input text_ok, input fault_code, input byte_count,
		output ready);
endinterface

// ===== design/utf8_name_validator.sv =====
// Top level: byte-serial UTF-8 name validator with length limit.
//
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+-------------------
//  text     | in  | data_byte[7:0], last_byte            | valid/ready
//  result   | out | text_ok, fault_code[2:0], byte_count | valid/ready
//  cfg      | in  | cfg_wdata[7:0] = max_bytes           | cfg_we, no ready
//
// One byte a cycle, sustained while no last byte waits on a held result. A
// beat is registered in the input stage and checked there against the
// per-string state; a last byte's verdict goes into the result register.
// Only the last byte of a string needs the result register; other bytes
// pass the check stage even while a result waits.
// arst_n clears all control state, max_bytes returns to 32.
// A result held by a stalled sink stalls the input stage only when a further
// last byte reaches it.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module utf8_name_validator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	utf8v_byte_if.sink           text,
	utf8v_res_if.source          result
);

	// configuration
	logic [7:0] max_bytes_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-string state
	logic [1:0]       pend_q;
	logic [1:0]       len_q;
	logic [20:0]      acc_q;
	utf8v_pkg::err_t  err_q;
	logic [8:0]       cnt_q;

	// result register
	logic       res_valid_q;
	logic       res_ok_q;
	logic [2:0] res_code_q;
	logic [8:0] res_cnt_q;

	// check stage
	logic             proc_go;
	logic [8:0]       cnt_next;
	logic [1:0]       pend_n;
	logic [1:0]       len_n;
	logic [20:0]      acc_n;
	logic [20:0]      shifted;
	logic [20:0]      lowest;
	logic             cp_bad;
	utf8v_pkg::err_t  chk_err;
	utf8v_pkg::err_t  err_new;

	// The check stage moves unless it holds a last byte and the result is
	// still occupied.
	assign proc_go    = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign text.ready = !valid_s1 || proc_go;

	assign cnt_next = (cnt_q == utf8v_pkg::COUNT_MAX) ? cnt_q : cnt_q + 9'd1;
	assign shifted  = {acc_q[14:0], byte_s1[5:0]};

	always_comb begin
		unique case (len_q)
			2'd1:    lowest = utf8v_pkg::CP_MIN_2;
			2'd2:    lowest = utf8v_pkg::CP_MIN_3;
			default: lowest = utf8v_pkg::CP_MIN_4;
		endcase
	end

	// Code point checks on the completed value: overlong, out of range,
	// C1 control, surrogate.
	assign cp_bad = (shifted < lowest) || (shifted > utf8v_pkg::CP_MAX)
		|| (shifted >= utf8v_pkg::C1_LO && shifted <= utf8v_pkg::C1_HI)
		|| (shifted >= utf8v_pkg::SURR_LO && shifted <= utf8v_pkg::SURR_HI);

	always_comb begin
		pend_n  = pend_q;
		len_n   = len_q;
		acc_n   = acc_q;
		chk_err = utf8v_pkg::ERR_NONE;
		if (pend_q == 2'd0) begin
			// expecting ASCII or a lead byte
			if (byte_s1 < utf8v_pkg::CTRL_LIMIT || byte_s1 == utf8v_pkg::DEL_BYTE) begin
				chk_err = utf8v_pkg::ERR_CONTROL;
			end else if (!byte_s1[7]) begin
				chk_err = utf8v_pkg::ERR_NONE;
			end else if (byte_s1[7:5] == 3'b110) begin
				len_n  = 2'd1;
				pend_n = 2'd1;
				acc_n  = {16'd0, byte_s1[4:0]};
			end else if (byte_s1[7:4] == 4'b1110) begin
				len_n  = 2'd2;
				pend_n = 2'd2;
				acc_n  = {17'd0, byte_s1[3:0]};
			end else if (byte_s1[7:3] == 5'b11110) begin
				len_n  = 2'd3;
				pend_n = 2'd3;
				acc_n  = {18'd0, byte_s1[2:0]};
			end else begin
				chk_err = utf8v_pkg::ERR_LEAD;
			end
		end else if (byte_s1[7:6] != 2'b10) begin
			chk_err = utf8v_pkg::ERR_CONT;
		end else begin
			acc_n  = shifted;
			pend_n = pend_q - 2'd1;
			if (pend_n == 2'd0 && cp_bad) begin
				chk_err = utf8v_pkg::ERR_POINT;
			end
		end
	end

	// First error wins; UTF-8 errors before length, length before truncation.
	always_comb begin
		if (err_q != utf8v_pkg::ERR_NONE) begin
			err_new = err_q;
		end else if (chk_err != utf8v_pkg::ERR_NONE) begin
			err_new = chk_err;
		end else if (cnt_next > {1'b0, max_bytes_q}) begin
			err_new = utf8v_pkg::ERR_LONG;
		end else if (last_s1 && pend_n != 2'd0) begin
			err_new = utf8v_pkg::ERR_TRUNC;
		end else begin
			err_new = utf8v_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= utf8v_pkg::MAX_BYTES_RST;
		end else if (cfg_we) begin
			max_bytes_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.data_byte;
			last_s1 <= text.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			len_q  <= 2'd0;
			acc_q  <= 21'd0;
			err_q  <= utf8v_pkg::ERR_NONE;
			cnt_q  <= 9'd0;
		end else if (proc_go) begin
			if (last_s1) begin
				pend_q <= 2'd0;
				len_q  <= 2'd0;
				acc_q  <= 21'd0;
				err_q  <= utf8v_pkg::ERR_NONE;
				cnt_q  <= 9'd0;
			end else begin
				// state frozen once an error is latched; only the count moves
				if (err_q == utf8v_pkg::ERR_NONE) begin
					pend_q <= pend_n;
					len_q  <= len_n;
					acc_q  <= acc_n;
				end
				err_q <= err_new;
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc_go && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_go && last_s1) begin
			res_ok_q   <= (err_new == utf8v_pkg::ERR_NONE);
			res_code_q <= err_new;
			res_cnt_q  <= cnt_next;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.text_ok    = res_ok_q;
	assign result.fault_code = res_code_q;
	assign result.byte_count = res_cnt_q;

	`ASSERT_NOW(a_ok_matches_code, res_valid_q, res_ok_q == (res_code_q == utf8v_pkg::ERR_NONE), "text_ok disagrees with fault_code")
	`ASSERT_NOW(a_count_nonzero, res_valid_q, res_cnt_q != 9'd0, "result with zero byte count")
	`ASSERT_NOW(a_pend_in_seq, pend_q != 2'd0, len_q != 2'd0 && pend_q <= len_q, "pending count exceeds sequence length")
	`ASSERT_NEXT(a_last_clears, proc_go && last_s1, res_valid_q && cnt_q == 9'd0 && err_q == utf8v_pkg::ERR_NONE, "string state not cleared after last byte")
	`ASSERT_NEXT(a_err_sticky, proc_go && !last_s1 && err_q != utf8v_pkg::ERR_NONE, err_q == $past(err_q), "latched error changed mid-string")

endmodule
